// ----- design/aeft_pkg.sv -----
// ============================================================================
// aeft_pkg
// Shared types and constants for the alternating-end filtered pick table.
// ============================================================================
`default_nettype none

package aeft_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    localparam int KEY_W   = 32;
    localparam int MACH_W  = 10;
    localparam int PROCS_W = 16;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_TAKE   = 2'd1,
        REQ_CLEAR  = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_NONE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CHK,
        S_INS_CMP,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [MACH_W-1:0]  machine;
        logic [PROCS_W-1:0] procs;
    } entry_t;

    typedef struct packed {
        logic               found;
        logic [MACH_W-1:0]  machine;
        logic [PROCS_W-1:0] count;
        status_t            status;
    } result_t;

endpackage

`default_nettype wire

// ----- design/alternating_end_filtered_pick_table.sv -----
// ============================================================================
// alternating_end_filtered_pick_table
// Sorted table of (key, machine, process count) with alternating-end pick.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one request: insert, take or
// clear. Every request returns exactly one result on the output channel
// (out_valid/out_ready): found, out_machine, out_count, status.
// The configuration channel (cfg_valid/cfg_ready) writes start_from_low,
// which also loads the current pick side; write it only while idle.
// Entries live in a single-port-read memory; one comparator is reused.
// Clear, an insert into a full table and a take from an empty table go
// straight to the result. An insert moves each larger entry up one slot,
// working down from the top, then writes its own entry. A take scans from
// the current pick side toward the other end; on a hit it moves every
// entry above the hit down one slot and flips the pick side. in_ready is
// low while a request is in progress. A result waits in the output
// register while the receiver stalls; the next request may start
// meanwhile but does not finish until that register is free. Reset
// empties the table and sets the pick side to the low-key end. Memory
// contents need no reset pass.
// ============================================================================
`default_nettype none

module alternating_end_filtered_pick_table #(
    parameter int TABLE_DEPTH = aeft_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [1:0]                    req_type,
    input  wire logic [aeft_pkg::KEY_W-1:0]    sort_key,
    input  wire logic [aeft_pkg::MACH_W-1:0]   machine_id,
    input  wire logic [aeft_pkg::PROCS_W-1:0]  proc_count,
    input  wire logic [aeft_pkg::PROCS_W-1:0]  max_procs,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               found,
    output logic [aeft_pkg::MACH_W-1:0]        out_machine,
    output logic [aeft_pkg::PROCS_W-1:0]       out_count,
    output logic [1:0]                         status,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic                          start_from_low
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    aeft_pkg::entry_t     wr_data;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    aeft_pkg::entry_t     rd_data;
    logic                 done;
    aeft_pkg::result_t    result;
    logic                 out_free;
    logic                 cfg_load;

    logic                 out_valid_reg;
    aeft_pkg::result_t    out_res_reg;

    assign cfg_ready = 1'b1;
    assign cfg_load  = cfg_valid & cfg_ready;
    assign out_free  = !out_valid_reg || out_ready;

    aeft_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    aeft_ctrl #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .sort_key   (sort_key),
        .machine_id (machine_id),
        .proc_count (proc_count),
        .max_procs  (max_procs),
        .cfg_load   (cfg_load),
        .cfg_side   (start_from_low),
        .out_free   (out_free),
        .done       (done),
        .result     (result),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_res_reg <= result;
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = out_res_reg.found;
    assign out_machine = out_res_reg.machine;
    assign out_count   = out_res_reg.count;
    assign status      = out_res_reg.status;

endmodule

`default_nettype wire

// ----- design/aeft_mem.sv -----
// ============================================================================
// aeft_mem
// Entry store: one write port, one read port with registered read data.
// ============================================================================
`default_nettype none

module aeft_mem #(
    parameter int DEPTH = aeft_pkg::TABLE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic            clk,
    input  wire logic            wr_en,
    input  wire logic [AW-1:0]   wr_addr,
    input  aeft_pkg::entry_t     wr_data,
    input  wire logic            rd_en,
    input  wire logic [AW-1:0]   rd_addr,
    output aeft_pkg::entry_t     rd_data
);

    aeft_pkg::entry_t mem [DEPTH];
    aeft_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- design/aeft_ctrl.sv -----
// ============================================================================
// aeft_ctrl
// Sequencer with one shared magnitude comparator: sorted insert, filtered
// scan from either end, compaction after a pick.
// ============================================================================
`default_nettype none

module aeft_ctrl #(
    parameter int DEPTH = aeft_pkg::TABLE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [1:0]                    req_type,
    input  wire logic [aeft_pkg::KEY_W-1:0]    sort_key,
    input  wire logic [aeft_pkg::MACH_W-1:0]   machine_id,
    input  wire logic [aeft_pkg::PROCS_W-1:0]  proc_count,
    input  wire logic [aeft_pkg::PROCS_W-1:0]  max_procs,
    input  wire logic                          cfg_load,
    input  wire logic                          cfg_side,
    input  wire logic                          out_free,
    output logic                               done,
    output aeft_pkg::result_t                  result,
    output logic                               wr_en,
    output logic [AW-1:0]                      wr_addr,
    output aeft_pkg::entry_t                   wr_data,
    output logic                               rd_en,
    output logic [AW-1:0]                      rd_addr,
    input  aeft_pkg::entry_t                   rd_data
);

    aeft_pkg::state_t                 state_reg, state_next;
    logic [aeft_pkg::KEY_W-1:0]       key_reg, key_next;
    logic [aeft_pkg::MACH_W-1:0]      mach_reg, mach_next;
    logic [aeft_pkg::PROCS_W-1:0]     procs_reg, procs_next;
    logic [aeft_pkg::PROCS_W-1:0]     limit_reg, limit_next;
    logic [CW-1:0]                    count_reg, count_next;
    logic [CW-1:0]                    pos_reg, pos_next;
    logic                             pick_low_reg, pick_low_next;
    aeft_pkg::result_t                res_reg, res_next;

    logic [aeft_pkg::KEY_W-1:0]       cmp_a;
    logic [aeft_pkg::KEY_W-1:0]       cmp_b;
    logic                             cmp_gt;
    logic [CW-1:0]                    pos_dec;
    logic [CW-1:0]                    pos_inc;
    aeft_pkg::entry_t                 new_entry;

    // shared comparator: key order on insert, eligibility on scan
    always_comb
    begin
        if (state_reg == aeft_pkg::S_INS_CMP)
        begin
            cmp_a = rd_data.key;
            cmp_b = key_reg;
        end
        else
        begin
            cmp_a = aeft_pkg::KEY_W'(rd_data.procs);
            cmp_b = aeft_pkg::KEY_W'(limit_reg);
        end
        cmp_gt = cmp_a > cmp_b;
    end

    assign pos_dec   = pos_reg - CW'(1);
    assign pos_inc   = pos_reg + CW'(1);
    assign new_entry = '{key: key_reg, machine: mach_reg, procs: procs_reg};
    assign result    = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= aeft_pkg::S_IDLE;
            count_reg    <= '0;
            pick_low_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            pick_low_reg <= pick_low_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        mach_reg  <= mach_next;
        procs_reg <= procs_next;
        limit_reg <= limit_next;
        pos_reg   <= pos_next;
        res_reg   <= res_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        key_next      = key_reg;
        mach_next     = mach_reg;
        procs_next    = procs_reg;
        limit_next    = limit_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        pick_low_next = pick_low_reg;
        res_next      = res_reg;
        in_ready      = 1'b0;
        done          = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = pos_reg[AW-1:0];
        wr_data       = new_entry;
        rd_en         = 1'b0;
        rd_addr       = pos_reg[AW-1:0];

        if (cfg_load)
        begin
            pick_low_next = cfg_side;
        end

        case (state_reg)
            aeft_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    key_next   = sort_key;
                    mach_next  = machine_id;
                    procs_next = proc_count;
                    limit_next = max_procs;
                    res_next   = '{found: 1'b0, machine: '0, count: '0,
                                   status: aeft_pkg::ST_OK};
                    state_next = aeft_pkg::S_FINISH;
                    case (req_type)
                        aeft_pkg::REQ_INSERT:
                        begin
                            if (count_reg == CW'(DEPTH))
                            begin
                                res_next.status = aeft_pkg::ST_FULL;
                            end
                            else
                            begin
                                pos_next   = count_reg;
                                state_next = aeft_pkg::S_INS_CHK;
                            end
                        end
                        aeft_pkg::REQ_TAKE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = aeft_pkg::ST_NONE;
                            end
                            else
                            begin
                                pos_next   = pick_low_reg ? '0 : count_reg - CW'(1);
                                state_next = aeft_pkg::S_SCAN_RD;
                            end
                        end
                        aeft_pkg::REQ_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            state_next = aeft_pkg::S_FINISH;
                        end
                    endcase
                end
            end

            aeft_pkg::S_INS_CHK:
            begin
                if (pos_reg == '0)
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CW'(1);
                    state_next = aeft_pkg::S_FINISH;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = pos_dec[AW-1:0];
                    state_next = aeft_pkg::S_INS_CMP;
                end
            end

            aeft_pkg::S_INS_CMP:
            begin
                wr_en = 1'b1;
                if (cmp_gt)
                begin
                    wr_data    = rd_data;
                    pos_next   = pos_dec;
                    state_next = aeft_pkg::S_INS_CHK;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                    state_next = aeft_pkg::S_FINISH;
                end
            end

            aeft_pkg::S_SCAN_RD:
            begin
                rd_en      = 1'b1;
                state_next = aeft_pkg::S_SCAN_CMP;
            end

            aeft_pkg::S_SCAN_CMP:
            begin
                if (!cmp_gt)
                begin
                    res_next      = '{found: 1'b1, machine: rd_data.machine,
                                      count: rd_data.procs,
                                      status: aeft_pkg::ST_OK};
                    pick_low_next = !pick_low_reg;
                    state_next    = aeft_pkg::S_SHIFT_RD;
                end
                else if (pick_low_reg ? (pos_inc == count_reg) : (pos_reg == '0))
                begin
                    res_next.status = aeft_pkg::ST_NONE;
                    state_next      = aeft_pkg::S_FINISH;
                end
                else
                begin
                    pos_next   = pick_low_reg ? pos_inc : pos_dec;
                    state_next = aeft_pkg::S_SCAN_RD;
                end
            end

            aeft_pkg::S_SHIFT_RD:
            begin
                if (pos_inc >= count_reg)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = aeft_pkg::S_FINISH;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = pos_inc[AW-1:0];
                    state_next = aeft_pkg::S_SHIFT_WR;
                end
            end

            aeft_pkg::S_SHIFT_WR:
            begin
                wr_en      = 1'b1;
                wr_data    = rd_data;
                pos_next   = pos_inc;
                state_next = aeft_pkg::S_SHIFT_RD;
            end

            aeft_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    done       = 1'b1;
                    state_next = aeft_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = aeft_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/aeft_chk.sv -----
// ============================================================================
// aeft_chk
// Port-level checks for the alternating-end filtered pick table.
// ============================================================================
`default_nettype none

module aeft_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        found,
    input wire logic [9:0]  out_machine,
    input wire logic [15:0] out_count,
    input wire logic [1:0]  status
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(found)
            && $stable(out_machine) && $stable(out_count) && $stable(status))
        else $error("stalled result changed");

    // in_ready drops once a request is accepted
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted on consecutive cycles");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> status == aeft_pkg::ST_OK)
        else $error("found with non-ok status");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> out_machine == '0 && out_count == '0)
        else $error("non-zero payload without a hit");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == aeft_pkg::ST_OK || status == aeft_pkg::ST_FULL
            || status == aeft_pkg::ST_NONE)
        else $error("bad status code");

endmodule

bind alternating_end_filtered_pick_table aeft_chk u_aeft_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .found       (found),
    .out_machine (out_machine),
    .out_count   (out_count),
    .status      (status)
);

`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the alternating-end filtered pick table.
// ----------------------------------------------------------------------------
// Requests are sent over the input handshake with random gaps. The result
// channel is stalled at random. A scoreboard model of the sorted table works
// out each expected result when its request is accepted, and a monitor
// compares every returned result, field by field, with the oldest one still
// waiting. The run covers directed corner cases, fills the table past full
// under both start sides, and then runs long random request mixes. The start
// side is rewritten between phases, and the final phase runs with no gaps.
// ============================================================================

module tb_top;
    import aeft_pkg::*;

    localparam int             DEPTH      = TABLE_DEPTH_DEF;
    localparam logic [1:0]     REQ_UNUSED = 2'd3;
    localparam logic [15:0]    PROCS_MAX  = 16'hFFFF;
    localparam logic [31:0]    KEY_MAX    = 32'hFFFF_FFFF;
    localparam logic [9:0]     MACH_MAX   = 10'h3FF;

    logic                   clk            = 1'b0;
    logic                   rst_n          = 1'b0;
    logic                   in_valid       = 1'b0;
    logic                   in_ready;
    logic [1:0]             req_type       = '0;
    logic [KEY_W-1:0]       sort_key       = '0;
    logic [MACH_W-1:0]      machine_id     = '0;
    logic [PROCS_W-1:0]     proc_count     = '0;
    logic [PROCS_W-1:0]     max_procs      = '0;
    logic                   out_valid;
    logic                   out_ready      = 1'b0;
    logic                   found;
    logic [MACH_W-1:0]      out_machine;
    logic [PROCS_W-1:0]     out_count;
    logic [1:0]             status;
    logic                   cfg_valid      = 1'b0;
    logic                   cfg_ready;
    logic                   start_from_low = 1'b1;

    // scoreboard model of the table
    entry_t                 pick_table[$];
    bit                     pick_low       = 1'b1;
    result_t                expected_results[$];
    int                     mismatch_count = 0;
    bit                     idle_on        = 1'b1;

    alternating_end_filtered_pick_table DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .sort_key       (sort_key),
        .machine_id     (machine_id),
        .proc_count     (proc_count),
        .max_procs      (max_procs),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .found          (found),
        .out_machine    (out_machine),
        .out_count      (out_count),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .start_from_low (start_from_low)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic result_t predict_pick(input logic [1:0] code,
                                             input logic [KEY_W-1:0] key,
                                             input logic [MACH_W-1:0] mach,
                                             input logic [PROCS_W-1:0] procs,
                                             input logic [PROCS_W-1:0] limit);
        result_t r;
        entry_t  e;
        int      pos;
        int      hit;
        r = '0;
        r.status = ST_OK;
        case (code)
            REQ_INSERT:
            begin
                if (pick_table.size() >= DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    pos = pick_table.size();
                    while (pos > 0 && pick_table[pos-1].key > key)
                        pos--;
                    e.key     = key;
                    e.machine = mach;
                    e.procs   = procs;
                    pick_table.insert(pos, e);
                end
            end
            REQ_TAKE:
            begin
                hit = -1;
                if (pick_low)
                begin
                    for (int i = 0; i < pick_table.size(); i++)
                        if (hit < 0 && pick_table[i].procs <= limit)
                            hit = i;
                end
                else
                begin
                    for (int i = pick_table.size() - 1; i >= 0; i--)
                        if (hit < 0 && pick_table[i].procs <= limit)
                            hit = i;
                end
                if (hit < 0)
                begin
                    r.status = ST_NONE;
                end
                else
                begin
                    r.found   = 1'b1;
                    r.machine = pick_table[hit].machine;
                    r.count   = pick_table[hit].procs;
                    pick_table.delete(hit);
                    pick_low = ~pick_low;
                end
            end
            REQ_CLEAR:
            begin
                pick_table.delete();
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned exp_v,
                                   input longint unsigned got_v);
        $display("MISMATCH %s: expected %0d got %0d at %0t", what, exp_v, got_v, $time);
        mismatch_count++;
    endtask

    task automatic compare_field(input string what, input int unsigned exp_v,
                                 input int unsigned got_v);
        if (exp_v != got_v)
            report_mismatch(what, 64'(exp_v), 64'(got_v));
    endtask

    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("result with no request waiting", 0, 1);
            end
            else
            begin
                exp_r = expected_results.pop_front();
                compare_field("found", 32'(exp_r.found), 32'(found));
                compare_field("out_machine", 32'(exp_r.machine), 32'(out_machine));
                compare_field("out_count", 32'(exp_r.count), 32'(out_count));
                compare_field("status", 32'(exp_r.status), 32'(status));
            end
        end
    end

    // result side back-pressure
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic send_request(input logic [1:0] code, input logic [KEY_W-1:0] key,
                                input logic [MACH_W-1:0] mach,
                                input logic [PROCS_W-1:0] procs,
                                input logic [PROCS_W-1:0] limit);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= code;
        sort_key   <= key;
        machine_id <= mach;
        proc_count <= procs;
        max_procs  <= limit;
        do @(posedge clk); while (!in_ready);
        expected_results.push_back(predict_pick(code, key, mach, procs, limit));
    endtask

    task automatic drain_requests();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_start_side(input bit side);
        drain_requests();
        cfg_valid      <= 1'b1;
        start_from_low <= side;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        pick_low = side;
    endtask

    function automatic logic [KEY_W-1:0] rand_key();
        if ($urandom_range(0, 1) == 0)
            return $urandom_range(0, 31);
        return $urandom;
    endfunction

    function automatic logic [PROCS_W-1:0] rand_procs();
        case ($urandom_range(0, 3))
            0, 1:    return PROCS_W'($urandom_range(0, 15));
            2:       return PROCS_W'($urandom);
            default: return $urandom_range(0, 1) ? PROCS_MAX : '0;
        endcase
    endfunction

    task automatic send_random();
        int unsigned pick;
        logic [1:0]  code;
        pick = $urandom_range(0, 99);
        if (pick < 47)
            code = REQ_INSERT;
        else if (pick < 94)
            code = REQ_TAKE;
        else if (pick < 97)
            code = REQ_CLEAR;
        else
            code = REQ_UNUSED;
        send_request(code, rand_key(), MACH_W'($urandom_range(0, 1023)), rand_procs(),
                     rand_procs());
    endtask

    task automatic test_directed();
        send_request(REQ_TAKE, $urandom, MACH_W'($urandom), PROCS_W'($urandom), PROCS_MAX);
        send_request(REQ_INSERT, 32'd100, 10'd1, 16'd5, PROCS_W'($urandom));
        send_request(REQ_INSERT, 32'd100, 10'd2, 16'd0, PROCS_W'($urandom));
        send_request(REQ_INSERT, '0, '0, PROCS_MAX, PROCS_W'($urandom));
        send_request(REQ_INSERT, KEY_MAX, MACH_MAX, PROCS_MAX, PROCS_W'($urandom));
        send_request(REQ_INSERT, 32'd50, 10'd3, 16'd7, PROCS_W'($urandom));
        send_request(REQ_TAKE, $urandom, MACH_W'($urandom), PROCS_W'($urandom), '0);
        send_request(REQ_TAKE, $urandom, MACH_W'($urandom), PROCS_W'($urandom), 16'd4);
        send_request(REQ_TAKE, $urandom, MACH_W'($urandom), PROCS_W'($urandom), PROCS_MAX);
        send_request(REQ_UNUSED, $urandom, MACH_W'($urandom), PROCS_W'($urandom),
                     PROCS_W'($urandom));
        send_request(REQ_TAKE, $urandom, MACH_W'($urandom), PROCS_W'($urandom), 16'd6);
        send_request(REQ_CLEAR, $urandom, MACH_W'($urandom), PROCS_W'($urandom),
                     PROCS_W'($urandom));
        send_request(REQ_TAKE, $urandom, MACH_W'($urandom), PROCS_W'($urandom), PROCS_MAX);
        send_request(REQ_INSERT, 32'd7, MACH_MAX, PROCS_MAX, PROCS_W'($urandom));
        send_request(REQ_INSERT, 32'd7, 10'd0, 16'd0, PROCS_W'($urandom));
        send_request(REQ_TAKE, $urandom, MACH_W'($urandom), PROCS_W'($urandom), PROCS_MAX);
        send_request(REQ_TAKE, $urandom, MACH_W'($urandom), PROCS_W'($urandom), PROCS_MAX);
        send_request(REQ_TAKE, $urandom, MACH_W'($urandom), PROCS_W'($urandom), PROCS_MAX);
    endtask

    // fill past full, then send more takes than entries, mostly permissive
    task automatic test_fill_overflow(input bit side);
        write_start_side(side);
        send_request(REQ_CLEAR, $urandom, MACH_W'($urandom), PROCS_W'($urandom),
                     PROCS_W'($urandom));
        repeat (DEPTH + 3)
            send_request(REQ_INSERT, rand_key(), MACH_W'($urandom_range(0, 1023)),
                         rand_procs(), PROCS_W'($urandom));
        repeat (DEPTH + 8)
            send_request(REQ_TAKE, $urandom, MACH_W'($urandom), PROCS_W'($urandom),
                         $urandom_range(0, 3) == 0 ? rand_procs() : PROCS_MAX);
    endtask

    task automatic test_random_mix(input bit side, input int count, input bit with_idle);
        write_start_side(side);
        idle_on = with_idle;
        repeat (count)
            send_random();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_fill_overflow(1'b0);
        test_fill_overflow(1'b1);
        test_random_mix(1'b1, 200, 1'b1);
        test_random_mix(1'b0, 200, 1'b1);
        test_random_mix(1'b1, 150, 1'b0);
        test_random_mix(1'($urandom_range(0, 1)), 200, 1'b1);
        test_random_mix(1'b0, 150, 1'b0);
        drain_requests();
        repeat (4 * DEPTH + 16) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch("results never returned", 64'(expected_results.size()), 0);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
